// ----- sv/pgnc_pkg.sv -----
`default_nettype none
package pgnc_pkg;

  // pixel word and configuration widths
  localparam int PIXEL_W    = 32;
  localparam int FORMAT_W   = 4;
  localparam int CFG_DATA_W = 4;
  localparam int CHAN_W     = 8;
  localparam int SHIFT_W    = 5;
  localparam int LUMA_W     = 24;

  // format codes at or above this are unknown
  localparam logic [FORMAT_W-1:0] NUM_KNOWN_FORMATS = 4'd12;

  typedef enum logic [FORMAT_W-1:0] {
    FMT_RGBA8888 = 4'd0,
    FMT_ARGB8888 = 4'd1,
    FMT_BGRA8888 = 4'd2,
    FMT_ABGR8888 = 4'd3,
    FMT_RGBA4444 = 4'd4,
    FMT_ARGB4444 = 4'd5,
    FMT_BGRA4444 = 4'd6,
    FMT_ABGR4444 = 4'd7,
    FMT_RGB24    = 4'd8,
    FMT_RGB888   = 4'd9,
    FMT_BGR24    = 4'd10,
    FMT_BGR888   = 4'd11
  } format_t;

  typedef enum logic {
    MODE_GRAY     = 1'b0,
    MODE_NEGATIVE = 1'b1
  } mode_t;

  // configuration register indexes
  typedef enum logic {
    CFG_PIXEL_FORMAT = 1'b0,
    CFG_EFFECT_MODE  = 1'b1
  } cfg_index_t;

  // Q0.16 rec709 luma weights
  localparam logic [LUMA_W-1:0] COEF_R = 24'd13938;
  localparam logic [LUMA_W-1:0] COEF_G = 24'd46869;
  localparam logic [LUMA_W-1:0] COEF_B = 24'd4730;

  localparam logic [CHAN_W-1:0] MASK_8BIT = 8'hFF;
  localparam logic [CHAN_W-1:0] MASK_4BIT = 8'h0F;

  // per format channel positions
  localparam logic [SHIFT_W-1:0] SHIFT_R [12] =
    '{5'd24, 5'd16, 5'd8, 5'd0, 5'd12, 5'd8, 5'd4, 5'd0, 5'd16, 5'd16, 5'd0, 5'd0};
  localparam logic [SHIFT_W-1:0] SHIFT_G [12] =
    '{5'd16, 5'd8, 5'd16, 5'd8, 5'd8, 5'd4, 5'd8, 5'd4, 5'd8, 5'd8, 5'd8, 5'd8};
  localparam logic [SHIFT_W-1:0] SHIFT_B [12] =
    '{5'd8, 5'd0, 5'd24, 5'd16, 5'd4, 5'd0, 5'd12, 5'd8, 5'd0, 5'd0, 5'd16, 5'd16};
  localparam logic [SHIFT_W-1:0] SHIFT_A [12] =
    '{5'd0, 5'd24, 5'd0, 5'd24, 5'd0, 5'd12, 5'd0, 5'd12, 5'd0, 5'd0, 5'd0, 5'd0};
  localparam logic WIDE_CHAN [12] =
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam logic HAS_ALPHA [12] =
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               unknown;
  } result_t;

  function automatic result_t convert(logic [PIXEL_W-1:0] pix,
                                      logic [FORMAT_W-1:0] fmt,
                                      mode_t mode);
    result_t              res;
    logic [CHAN_W-1:0]    mask;
    logic [CHAN_W-1:0]    r;
    logic [CHAN_W-1:0]    g;
    logic [CHAN_W-1:0]    b;
    logic [CHAN_W-1:0]    a;
    logic [LUMA_W-1:0]    luma;
    logic [SHIFT_W-1:0]   sr;
    logic [SHIFT_W-1:0]   sg;
    logic [SHIFT_W-1:0]   sb;
    logic [SHIFT_W-1:0]   sa;
    logic [PIXEL_W-1:0]   word;
    res = '0;
    if (fmt >= NUM_KNOWN_FORMATS) begin
      res.pixel   = pix;
      res.unknown = 1'b1;
    end else begin
      sr   = SHIFT_R[fmt];
      sg   = SHIFT_G[fmt];
      sb   = SHIFT_B[fmt];
      sa   = SHIFT_A[fmt];
      mask = WIDE_CHAN[fmt] ? MASK_8BIT : MASK_4BIT;
      r    = CHAN_W'(pix >> sr) & mask;
      g    = CHAN_W'(pix >> sg) & mask;
      b    = CHAN_W'(pix >> sb) & mask;
      a    = CHAN_W'(pix >> sa) & mask;
      if (mode == MODE_GRAY) begin
        // weights sum to 65537, so the top byte never overflows the channel
        luma = COEF_R * LUMA_W'(r) + COEF_G * LUMA_W'(g) + COEF_B * LUMA_W'(b);
        r    = luma[LUMA_W-1:16] & mask;
        g    = r;
        b    = r;
      end else begin
        r = mask - r;
        g = mask - g;
        b = mask - b;
      end
      word = (PIXEL_W'(r) << sr) | (PIXEL_W'(g) << sg) | (PIXEL_W'(b) << sb);
      if (HAS_ALPHA[fmt]) begin
        word = word | (PIXEL_W'(a) << sa);
      end
      res.pixel   = word;
      res.unknown = 1'b0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pgnc_in_if.sv -----
`default_nettype none
interface pgnc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pgnc_pkg::PIXEL_W-1:0]  in_pixel;

  modport source (output valid, output in_pixel, input ready);
  modport sink   (input valid, input in_pixel, output ready);
endinterface
`default_nettype wire

// ----- sv/pgnc_out_if.sv -----
`default_nettype none
interface pgnc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pgnc_pkg::PIXEL_W-1:0]  out_pixel;
  logic                          format_unknown;

  modport source (output valid, output out_pixel, output format_unknown, input ready);
  modport sink   (input valid, input out_pixel, input format_unknown, output ready);
endinterface
`default_nettype wire

// ----- sv/pixel_grayscale_negative_converter.sv -----
`default_nettype none
// Pixel grayscale / colour-negative converter. Each request on in_ch carries one packed
// pixel, which is unpacked by the pixel_format register (8888 and 4444 in RGBA, ARGB, BGRA
// and ABGR orders, or 24-bit RGB/BGR without alpha), then turned into truncated rec709
// luma (written into every colour channel) or colour-inverted against the channel maximum,
// depending on effect_mode, and repacked in the same format with alpha kept. Unused high
// bits of the result are zero. Format codes 12 to 15 pass the pixel through untouched and
// set format_unknown. The block takes one pixel per clock when out_ch keeps up: a pixel
// is held first in the input register and then in the result register, and the luma
// multiply-add sits between the two. in_ch.ready drops only when both stages
// hold a pixel and the result is not taken. Write the configuration only while no pixel
// is in flight; writes with cfg_we high land at the next rising edge.
module pixel_grayscale_negative_converter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [pgnc_pkg::CFG_DATA_W-1:0]   cfg_data,
  pgnc_in_if.sink                                in_ch,
  pgnc_out_if.source                             out_ch
);

  // configuration registers
  logic [pgnc_pkg::FORMAT_W-1:0] fmt_r;
  pgnc_pkg::mode_t               mode_r;

  // input stage
  logic                          s1_valid_r;
  logic [pgnc_pkg::PIXEL_W-1:0]  pix_r;

  // result stage
  logic                          out_valid_r;
  pgnc_pkg::result_t             res_r;
  pgnc_pkg::result_t             res_nxt;

  logic adv;
  logic in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= '0;
      mode_r <= pgnc_pkg::MODE_GRAY;
    end else if (cfg_we) begin
      unique case (pgnc_pkg::cfg_index_t'(cfg_index))
        pgnc_pkg::CFG_PIXEL_FORMAT: fmt_r  <= cfg_data;
        pgnc_pkg::CFG_EFFECT_MODE:  mode_r <= pgnc_pkg::mode_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // result stage can load when empty or being drained
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pix_r <= in_ch.in_pixel;
    end
  end

  // unpack, convert and repack in one pass
  always_comb begin
    res_nxt = pgnc_pkg::convert(pix_r, fmt_r, mode_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_pixel      = res_r.pixel;
  assign out_ch.format_unknown = res_r.unknown;

`ifndef SYNTHESIS
  // unknown format passes the buffered pixel straight through
  a_unknown_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && fmt_r >= pgnc_pkg::NUM_KNOWN_FORMATS)
      |=> (out_ch.format_unknown && out_ch.out_pixel == $past(pix_r)))
    else $error("unknown format did not pass the pixel through");

  // 4444 results never touch the upper half word
  a_4444_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (fmt_r == pgnc_pkg::FMT_RGBA4444 || fmt_r == pgnc_pkg::FMT_ARGB4444 ||
                     fmt_r == pgnc_pkg::FMT_BGRA4444 || fmt_r == pgnc_pkg::FMT_ABGR4444))
      |-> (out_ch.out_pixel[31:16] == 16'h0000 && !out_ch.format_unknown))
    else $error("4444 result has bits above bit 15");

  // no new request while both stages are full and the result is stalled
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while pipeline full");

  // a taken request reaches the input stage
  a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (s1_valid_r && pix_r == $past(in_ch.in_pixel)))
    else $error("accepted pixel lost at input stage");
`endif

endmodule
`default_nettype wire

// ----- tb/pixel_grayscale_negative_converter_test.sv -----
`timescale 1ns / 1ps
module pixel_grayscale_negative_converter_test;

  // rec709 luma weights, Q0.16
  localparam int unsigned WEIGHT_R = 13938;
  localparam int unsigned WEIGHT_G = 46869;
  localparam int unsigned WEIGHT_B = 4730;

  localparam int PIX_W = pgnc_pkg::PIXEL_W;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic                            cfg_index;
  logic [pgnc_pkg::CFG_DATA_W-1:0] cfg_data;

  pgnc_in_if  in_ch();
  pgnc_out_if out_ch();

  pixel_grayscale_negative_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // our own copy of the two registers, as the block should hold them
  logic [pgnc_pkg::FORMAT_W-1:0]  fmt_now;
  pgnc_pkg::mode_t                mode_now;

  logic [PIX_W-1:0]               pixels_to_send [$];
  pgnc_pkg::result_t              pending_results [$];
  pgnc_pkg::result_t              want;

  int  n_issued;
  int  n_results;
  int  n_checked;
  int  n_unknown;
  int  n_errors;
  int  n_settings;
  int  send_gap;
  int  sink_gap;
  bit  calm;

  // converted pixel for the current format and mode
  function automatic pgnc_pkg::result_t recolour(logic [PIX_W-1:0] pix);
    pgnc_pkg::result_t  res;
    logic [4:0]         sr;
    logic [4:0]         sg;
    logic [4:0]         sb;
    logic [4:0]         sa;
    logic [7:0]         top;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [7:0]         a;
    logic               wide;
    logic               alpha;
    int unsigned        luma;
    logic [PIX_W-1:0]   word;
    res = '0;
    // unknown code: pixel goes straight through with the flag up
    if (fmt_now >= pgnc_pkg::NUM_KNOWN_FORMATS) begin
      res.pixel   = pix;
      res.unknown = 1'b1;
      return res;
    end
    wide  = 1'b1;
    alpha = 1'b1;
    // first channel named sits in the highest used bits
    unique case (pgnc_pkg::format_t'(fmt_now))
      pgnc_pkg::FMT_RGBA8888: {sr, sg, sb, sa} = {5'd24, 5'd16, 5'd8, 5'd0};
      pgnc_pkg::FMT_ARGB8888: {sr, sg, sb, sa} = {5'd16, 5'd8, 5'd0, 5'd24};
      pgnc_pkg::FMT_BGRA8888: {sr, sg, sb, sa} = {5'd8, 5'd16, 5'd24, 5'd0};
      pgnc_pkg::FMT_ABGR8888: {sr, sg, sb, sa} = {5'd0, 5'd8, 5'd16, 5'd24};
      pgnc_pkg::FMT_RGBA4444: begin
        {sr, sg, sb, sa} = {5'd12, 5'd8, 5'd4, 5'd0};
        wide = 1'b0;
      end
      pgnc_pkg::FMT_ARGB4444: begin
        {sr, sg, sb, sa} = {5'd8, 5'd4, 5'd0, 5'd12};
        wide = 1'b0;
      end
      pgnc_pkg::FMT_BGRA4444: begin
        {sr, sg, sb, sa} = {5'd4, 5'd8, 5'd12, 5'd0};
        wide = 1'b0;
      end
      pgnc_pkg::FMT_ABGR4444: begin
        {sr, sg, sb, sa} = {5'd0, 5'd4, 5'd8, 5'd12};
        wide = 1'b0;
      end
      pgnc_pkg::FMT_RGB24, pgnc_pkg::FMT_RGB888: begin
        {sr, sg, sb, sa} = {5'd16, 5'd8, 5'd0, 5'd0};
        alpha = 1'b0;
      end
      default: begin
        // bgr24 and bgr888
        {sr, sg, sb, sa} = {5'd0, 5'd8, 5'd16, 5'd0};
        alpha = 1'b0;
      end
    endcase
    top = wide ? 8'hFF : 8'h0F;
    r   = 8'(pix >> sr) & top;
    g   = 8'(pix >> sg) & top;
    b   = 8'(pix >> sb) & top;
    a   = 8'(pix >> sa) & top;
    if (mode_now == pgnc_pkg::MODE_GRAY) begin
      // truncated luma into every colour channel
      luma = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
      r    = 8'(luma >> 16) & top;
      g    = r;
      b    = r;
    end else begin
      r = top - r;
      g = top - g;
      b = top - b;
    end
    word = (PIX_W'(r) << sr) | (PIX_W'(g) << sg) | (PIX_W'(b) << sb);
    if (alpha) begin
      word = word | (PIX_W'(a) << sa);
    end
    res.pixel   = word;
    res.unknown = 1'b0;
    return res;
  endfunction

  // request driver: pops the pixel queue, predicts on every accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(recolour(in_ch.in_pixel));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          // idle burst
          in_ch.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (pixels_to_send.size() != 0) begin
          in_ch.valid    <= 1'b1;
          in_ch.in_pixel <= pixels_to_send.pop_front();
          if (!calm && $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(1, 3);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results <= n_results + 1;
        if (pending_results.size() == 0) begin
          $error("out_pixel: got 0x%08h with no request outstanding", out_ch.out_pixel);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.out_pixel !== want.pixel) begin
            $error("out_pixel: expected 0x%08h, got 0x%08h", want.pixel, out_ch.out_pixel);
            n_errors++;
          end
          if (out_ch.format_unknown !== want.unknown) begin
            $error("format_unknown: expected %0b, got %0b", want.unknown,
                   out_ch.format_unknown);
            n_errors++;
          end
          n_checked <= n_checked + 1;
          if (want.unknown) begin
            n_unknown <= n_unknown + 1;
          end
        end
      end
      if (sink_gap > 0) begin
        out_ch.ready <= 1'b0;
        sink_gap     <= sink_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) begin
          sink_gap <= $urandom_range(1, 3);
        end
      end
    end
  end

  task automatic set_register(pgnc_pkg::cfg_index_t idx,
                              logic [pgnc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // only the register's own width counts
    if (idx == pgnc_pkg::CFG_PIXEL_FORMAT) begin
      fmt_now = val[pgnc_pkg::FORMAT_W-1:0];
    end else begin
      mode_now = pgnc_pkg::mode_t'(val[0]);
    end
  endtask

  task automatic choose_setting(logic [pgnc_pkg::FORMAT_W-1:0] fmt,
                                logic [pgnc_pkg::CFG_DATA_W-1:0] mode_word);
    set_register(pgnc_pkg::CFG_PIXEL_FORMAT, fmt);
    set_register(pgnc_pkg::CFG_EFFECT_MODE, mode_word);
    n_settings++;
  endtask

  task automatic send(logic [PIX_W-1:0] pix);
    pixels_to_send.push_back(pix);
    n_issued++;
  endtask

  // every request gives exactly one result, so count them home
  task automatic drain();
    while (n_results < n_issued) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int                 order [32];
    int                 j;
    int                 swap;
    int                 n;
    logic [PIX_W-1:0]   pix;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = pgnc_pkg::CFG_PIXEL_FORMAT;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_pixel = '0;
    out_ch.ready   = 1'b0;
    fmt_now        = pgnc_pkg::FMT_RGBA8888;
    mode_now       = pgnc_pkg::MODE_GRAY;
    calm           = 1'b0;
    n_issued       = 0;
    n_results      = 0;
    n_checked      = 0;
    n_unknown      = 0;
    n_errors       = 0;
    n_settings     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: rgba8888 grayscale, black, white and each channel alone
    send(32'h0000_0000);
    send(32'hFFFF_FFFF);
    send(32'hFF00_0000);
    send(32'h00FF_0000);
    send(32'h0000_FF00);
    send(32'h0000_00FF);
    drain();

    // 4444 negative against 15, upper half ignored, mode data with spare bits set
    choose_setting(pgnc_pkg::FMT_ABGR4444, 4'b1111);
    send(32'hFFFF_0000);
    send(32'h0000_FFFF);
    send(32'h1234_5A5A);
    drain();

    // bgr888 luma, byte above the pixel ignored and cleared
    choose_setting(pgnc_pkg::FMT_BGR888, 4'(pgnc_pkg::MODE_GRAY));
    send(32'hFF00_0000);
    send(32'h00FF_FFFF);
    send(32'h00FF_0000);
    drain();

    // bgra8888 negative repacks in its own order
    choose_setting(pgnc_pkg::FMT_BGRA8888, 4'(pgnc_pkg::MODE_NEGATIVE));
    send(32'h1122_3344);
    send(32'hFF00_FF00);
    drain();

    // unknown codes pass through in either mode
    choose_setting(4'd15, 4'(pgnc_pkg::MODE_GRAY));
    send(32'hFFFF_FFFF);
    send(32'h0000_0000);
    drain();
    choose_setting(4'd12, 4'(pgnc_pkg::MODE_NEGATIVE));
    send(32'hDEAD_BEEF);
    send(32'h89AB_CDEF);
    drain();

    // mode bit clear under spare bits set, 24-bit without alpha
    choose_setting(pgnc_pkg::FMT_RGB24, 4'b1110);
    send(32'h00FF_FFFF);
    send(32'hFFFF_FFFF);
    drain();

    // random part: every format code in both modes, shuffled
    for (int i = 0; i < 32; i++) begin
      order[i] = i;
    end
    for (int i = 31; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < 32; i++) begin
      // the last few settings run without any idling
      if (i >= 29) begin
        calm = 1'b1;
      end
      choose_setting(4'(order[i] >> 1), {3'($urandom_range(0, 7)), 1'(order[i])});
      n = $urandom_range(30, 60);
      repeat (n) begin
        if ($urandom_range(0, 9) < 7) begin
          pix = $urandom;
        end else begin
          // channel extremes, byte and nibble alike
          for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 4))
              0: pix[8*k +: 8] = 8'h00;
              1: pix[8*k +: 8] = 8'hFF;
              2: pix[8*k +: 8] = 8'h0F;
              3: pix[8*k +: 8] = 8'hF0;
              default: pix[8*k +: 8] = 8'($urandom);
            endcase
          end
        end
        send(pix);
      end
      drain();
    end

    $display("%0d pixels checked over %0d register settings, all 16 format codes in both modes",
             n_checked, n_settings + 1);
    $display("%0d of them went through the unknown-format path", n_unknown);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
